>>> hw/rtl/pbrq_pkg.sv
// shared types and constants for the priority bitmap ready queue
package pbrq_pkg;

  // item field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned THREAD_W = 6;
  localparam int unsigned LEVEL_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the item and issue the first memory reads
    logic fetch;   // pop only: reread the link memories at the head thread
    logic update;  // write the lists back and register the result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_req; // item on the input ports is a pop
  } status_t;

endpackage

>>> hw/rtl/pbrq_ctrl.sv
// controller state machine for the priority bitmap ready queue
module pbrq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pbrq_pkg::status_t status,
  output pbrq_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done
);
  import pbrq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_FETCH  = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = status.pop_req ? ST_FETCH : ST_UPDATE;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.update;
    end
  end

endmodule

>>> hw/rtl/pbrq_datapath.sv
// list memories, flags, level bitmap and update logic of the ready queue
module pbrq_datapath #(
  parameter int unsigned LEVELS  = 32,
  parameter int unsigned THREADS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pbrq_pkg::cmd_t                     cmd,
  input  logic [pbrq_pkg::OP_W-1:0]          operation,
  input  logic [pbrq_pkg::THREAD_W-1:0]      thread_index,
  input  logic [pbrq_pkg::LEVEL_W-1:0]       priority_level,
  output pbrq_pkg::status_t                  status,
  output logic [pbrq_pkg::THREAD_W-1:0]      popped_thread,
  output logic                               found,
  output logic                               error
);
  import pbrq_pkg::*;

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned TW = (THREADS > 1) ? $clog2(THREADS) : 1;

  // lowest set bit of the level bitmap, the best non-empty level
  function automatic logic [LW-1:0] best_level(input logic [LEVELS-1:0] m);
    logic [LW-1:0] b;
    b = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (m[i]) b = LW'(i);
    end
    return b;
  endfunction

  // memories
  logic [TW-1:0] head_mem  [LEVELS];
  logic [TW-1:0] tail_mem  [LEVELS];
  logic [TW-1:0] next_mem  [THREADS];
  logic [TW-1:0] prev_mem  [THREADS];
  logic [LW-1:0] level_mem [THREADS];

  // flag and bitmap registers
  logic [LEVELS-1:0]  level_mask;
  logic [THREADS-1:0] has_next;
  logic [THREADS-1:0] has_prev;
  logic [THREADS-1:0] queued;

  // captured item
  logic [OP_W-1:0] op_q;
  logic [TW-1:0]   thr_q;
  logic [LW-1:0]   lv_q;
  logic            valid_q;
  logic            hit_q;

  // registered read data
  logic [TW-1:0] head_rd, tail_rd, next_rd, prev_rd;
  logic [LW-1:0] level_rd;

  // input decode
  logic [LW-1:0] lv_in;
  logic [TW-1:0] thr_in;
  logic          thr_ok;
  logic [TW-1:0] link_raddr;

  assign status.pop_req = (operation == OP_POP);
  assign thr_in = TW'(thread_index);
  assign thr_ok = ({3'b000, thread_index} < 9'(THREADS));
  assign lv_in  = ({1'b0, priority_level} >= 6'(LEVELS)) ? LW'(LEVELS - 1)
                                                         : LW'(priority_level);
  assign link_raddr = cmd.load ? thr_in : head_rd;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      thr_q   <= thr_in;
      lv_q    <= lv_in;
      valid_q <= thr_ok;
      hit_q   <= (level_mask != '0);
    end else if (cmd.fetch) begin
      thr_q <= head_rd;
    end
  end

  // memory reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      head_rd <= head_mem[best_level(level_mask)];
      tail_rd <= tail_mem[lv_in];
    end
    if (cmd.load || cmd.fetch) begin
      next_rd  <= next_mem[link_raddr];
      prev_rd  <= prev_mem[link_raddr];
      level_rd <= level_mem[link_raddr];
    end
  end

  // update decode
  logic cur_queued, cur_hp, cur_hn, lv_busy;
  logic do_enq, do_rem;

  assign cur_queued = queued[thr_q];
  assign cur_hp     = has_prev[thr_q];
  assign cur_hn     = has_next[thr_q];
  assign lv_busy    = level_mask[lv_q];

  assign do_enq = cmd.update && valid_q && (op_q == OP_ENQUEUE) && !cur_queued;
  assign do_rem = cmd.update &&
                  ((valid_q && (op_q == OP_REMOVE) && cur_queued) ||
                   ((op_q == OP_POP) && hit_q));

  // memory write ports
  logic          next_we, prev_we, head_we, tail_we;
  logic [TW-1:0] next_wa, next_wd, prev_wa, prev_wd, head_wd, tail_wd;
  logic [LW-1:0] head_wa, tail_wa;

  always_comb begin
    next_we = 1'b0; next_wa = tail_rd; next_wd = thr_q;
    prev_we = 1'b0; prev_wa = thr_q;   prev_wd = tail_rd;
    head_we = 1'b0; head_wa = lv_q;    head_wd = thr_q;
    tail_we = 1'b0; tail_wa = lv_q;    tail_wd = thr_q;
    if (do_enq) begin
      // append at the tail, or start a new list
      next_we = lv_busy;
      prev_we = lv_busy;
      head_we = !lv_busy;
      tail_we = 1'b1;
    end else if (do_rem) begin
      // unlink from the neighbors, or move head and tail
      next_we = cur_hp;  next_wa = prev_rd;  next_wd = next_rd;
      prev_we = cur_hn;  prev_wa = next_rd;  prev_wd = prev_rd;
      head_we = !cur_hp && cur_hn;  head_wa = level_rd;  head_wd = next_rd;
      tail_we = cur_hp && !cur_hn;  tail_wa = level_rd;  tail_wd = prev_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (do_enq)  level_mem[thr_q]  <= lv_q;
  end

  // link flags and level bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      level_mask <= '0;
      has_next   <= '0;
      has_prev   <= '0;
      queued     <= '0;
    end else if (do_enq) begin
      has_next[thr_q] <= 1'b0;
      has_prev[thr_q] <= lv_busy;
      queued[thr_q]   <= 1'b1;
      if (lv_busy) begin
        has_next[tail_rd] <= 1'b1;
      end else begin
        level_mask[lv_q] <= 1'b1;
      end
    end else if (do_rem) begin
      if (cur_hp) has_next[prev_rd] <= cur_hn;
      if (cur_hn) has_prev[next_rd] <= cur_hp;
      if (!cur_hp && !cur_hn) level_mask[level_rd] <= 1'b0;
      has_next[thr_q] <= 1'b0;
      has_prev[thr_q] <= 1'b0;
      queued[thr_q]   <= 1'b0;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      popped_thread <= '0;
      found         <= 1'b0;
      error         <= 1'b0;
      priority if (op_q == OP_POP) begin
        if (hit_q) begin
          popped_thread <= THREAD_W'(thr_q);
          found         <= 1'b1;
        end
      end else if (valid_q && (op_q == OP_ENQUEUE)) begin
        error <= cur_queued;
      end else if (valid_q && (op_q == OP_REMOVE)) begin
        error <= !cur_queued;
      end
    end
  end

endmodule

>>> hw/rtl/priority_bitmap_ready_queue.sv
// top level of the priority bitmap ready queue
//
//   channel   ports                                          handshake
//   command   operation, thread_index, priority_level        start, busy
//   result    popped_thread, found, error                    done
//
// An item is taken at an edge with start high and busy low; its result is
// shown for one cycle with done high and cannot be held off.
// Enqueue and remove take 2 cycles: one registered read of the link and level
// memories, then one write-back cycle. Pop takes 3 cycles, since the head
// thread must be read from the head memory before its links can be read.
// rst is synchronous; it clears the bitmap and the per-thread flags at once.
module priority_bitmap_ready_queue #(
  parameter int unsigned LEVELS  = 32,
  parameter int unsigned THREADS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pbrq_pkg::OP_W-1:0]     operation,
  input  logic [pbrq_pkg::THREAD_W-1:0] thread_index,
  input  logic [pbrq_pkg::LEVEL_W-1:0]  priority_level,
  output logic                          done,
  output logic [pbrq_pkg::THREAD_W-1:0] popped_thread,
  output logic                          found,
  output logic                          error
);
  import pbrq_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  pbrq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // lists and bitmap
  pbrq_datapath #(
    .LEVELS  (LEVELS),
    .THREADS (THREADS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .operation      (operation),
    .thread_index   (thread_index),
    .priority_level (priority_level),
    .status         (status),
    .popped_thread  (popped_thread),
    .found          (found),
    .error          (error)
  );

endmodule

>>> test/ready_queue_checker.sv
`timescale 1ns / 100ps
// checker that predicts and compares every result of the priority bitmap ready queue
module ready_queue_checker #(
  parameter int unsigned LEVELS  = 32,
  parameter int unsigned THREADS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [pbrq_pkg::OP_W-1:0]     operation,
  input  logic [pbrq_pkg::THREAD_W-1:0] thread_index,
  input  logic [pbrq_pkg::LEVEL_W-1:0]  priority_level,
  input  logic                          done,
  input  logic [pbrq_pkg::THREAD_W-1:0] popped_thread,
  input  logic                          found,
  input  logic                          error,
  output int                            mismatch_count,
  output int                            results_pending
);

  import pbrq_pkg::*;

  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic                found;
    logic                error;
  } queue_result_t;

  localparam int unsigned PEND_DEPTH = 8;

  // shadow copy of the ready queue
  logic [LEVELS-1:0]   level_mask;
  logic [THREAD_W-1:0] head_of [LEVELS];
  logic [THREAD_W-1:0] tail_of [LEVELS];
  logic [THREAD_W-1:0] next_of [THREADS];
  logic [THREAD_W-1:0] prev_of [THREADS];
  logic                link_next [THREADS];
  logic                link_prev [THREADS];
  logic                queued [THREADS];
  logic [LEVEL_W-1:0]  level_of [THREADS];

  // predicted results waiting for the block, oldest at pend_rd
  queue_result_t pending_buf [PEND_DEPTH];
  int            pend_rd;
  int            pend_wr;
  int            pend_fill;

  // append a thread at the tail of its level, returns the error flag
  function automatic logic append_thread(input int t, input int lv);
    int tl;
    if (queued[t]) return 1'b1;
    if (lv >= LEVELS) lv = LEVELS - 1;
    link_next[t] = 1'b0;
    next_of[t] = '0;
    if (level_mask[lv]) begin
      tl = tail_of[lv];
      prev_of[t] = THREAD_W'(tl);
      link_prev[t] = 1'b1;
      next_of[tl] = THREAD_W'(t);
      link_next[tl] = 1'b1;
    end else begin
      prev_of[t] = '0;
      link_prev[t] = 1'b0;
      head_of[lv] = THREAD_W'(t);
      level_mask[lv] = 1'b1;
    end
    tail_of[lv] = THREAD_W'(t);
    queued[t] = 1'b1;
    level_of[t] = LEVEL_W'(lv);
    return 1'b0;
  endfunction

  // unlink a thread from anywhere in its level, returns the error flag
  function automatic logic unlink_thread(input int t);
    int lv;
    int p;
    int n;
    if (!queued[t]) return 1'b1;
    lv = level_of[t];
    p = prev_of[t];
    n = next_of[t];
    if (link_prev[t]) begin
      next_of[p] = THREAD_W'(n);
      link_next[p] = link_next[t];
    end else if (link_next[t]) begin
      head_of[lv] = THREAD_W'(n);
    end
    if (link_next[t]) begin
      prev_of[n] = THREAD_W'(p);
      link_prev[n] = link_prev[t];
    end else if (link_prev[t]) begin
      tail_of[lv] = THREAD_W'(p);
    end
    // last thread of the level leaves
    if (!link_prev[t] && !link_next[t]) level_mask[lv] = 1'b0;
    link_next[t] = 1'b0;
    link_prev[t] = 1'b0;
    next_of[t] = '0;
    prev_of[t] = '0;
    queued[t] = 1'b0;
    return 1'b0;
  endfunction

  // apply one item to the shadow queue and return its result
  function automatic queue_result_t apply_queue_op(input logic [OP_W-1:0] op,
                                                   input int t, input int lv);
    queue_result_t r;
    int best;
    r = '0;
    case (op)
      OP_POP: begin
        if (level_mask != '0) begin
          best = 0;
          while (!level_mask[best]) best++;
          r.thread = head_of[best];
          r.found = 1'b1;
          void'(unlink_thread(int'(r.thread)));
        end
      end
      OP_ENQUEUE: begin
        if (t < THREADS) r.error = append_thread(t, lv);
      end
      OP_REMOVE: begin
        if (t < THREADS) r.error = unlink_thread(t);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      level_mask = '0;
      for (int i = 0; i < THREADS; i++) begin
        link_next[i] = 1'b0;
        link_prev[i] = 1'b0;
        queued[i] = 1'b0;
      end
      pend_rd = 0;
      pend_wr = 0;
      pend_fill = 0;
      mismatch_count <= 0;
      results_pending <= 0;
    end else begin
      // compare the result with the oldest prediction
      if (done) begin
        if (pend_fill == 0) begin
          $display("%0t: result with no item waiting: thread %0d found %0d error %0d",
                   $time, popped_thread, found, error);
          errs++;
        end else begin
          want = pending_buf[pend_rd];
          pend_rd = (pend_rd + 1) % PEND_DEPTH;
          pend_fill--;
          if (popped_thread !== want.thread) begin
            $display("%0t: popped_thread expected %0d actual %0d",
                     $time, want.thread, popped_thread);
            errs++;
          end
          if (found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
            errs++;
          end
          if (error !== want.error) begin
            $display("%0t: error expected %0d actual %0d", $time, want.error, error);
            errs++;
          end
        end
      end
      // predict the result of an accepted item
      if (start && !busy) begin
        if (pend_fill == PEND_DEPTH) begin
          $display("%0t: items waiting expected at most %0d actual %0d",
                   $time, PEND_DEPTH, pend_fill + 1);
          errs++;
        end else begin
          pending_buf[pend_wr] = apply_queue_op(operation, int'(thread_index),
                                                int'(priority_level));
          pend_wr = (pend_wr + 1) % PEND_DEPTH;
          pend_fill++;
        end
      end
      mismatch_count <= mismatch_count + errs;
      results_pending <= pend_fill;
    end
  end

endmodule

>>> test/priority_bitmap_ready_queue_test.sv
`timescale 1ns / 100ps
// top of the ready queue testbench: clock, reset, item stimulus and verdict
module priority_bitmap_ready_queue_test;

  import pbrq_pkg::*;

  localparam int unsigned LEVELS  = 32;
  localparam int unsigned THREADS = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     operation = OP_ENQUEUE;
  logic [THREAD_W-1:0] thread_index = '0;
  logic [LEVEL_W-1:0]  priority_level = '0;
  logic                busy;
  logic                done;
  logic [THREAD_W-1:0] popped_thread;
  logic                found;
  logic                error;
  int                  mismatch_count;
  int                  results_pending;

  priority_bitmap_ready_queue #(.LEVELS(LEVELS), .THREADS(THREADS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .thread_index(thread_index), .priority_level(priority_level),
    .done(done), .popped_thread(popped_thread), .found(found), .error(error)
  );

  ready_queue_checker #(.LEVELS(LEVELS), .THREADS(THREADS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .thread_index(thread_index), .priority_level(priority_level),
    .done(done), .popped_thread(popped_thread), .found(found), .error(error),
    .mismatch_count(mismatch_count), .results_pending(results_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hold the item on the ports until the block takes it
  task automatic issue(input logic [OP_W-1:0] op, input int t, input int lv);
    start <= 1'b1;
    operation <= op;
    thread_index <= THREAD_W'(t);
    priority_level <= LEVEL_W'(lv);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random sender gap with junk on the item ports
  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      do begin
        start <= 1'b0;
        operation <= OP_W'($urandom);
        thread_index <= THREAD_W'($urandom);
        priority_level <= LEVEL_W'($urandom);
        @(posedge clk);
      end while ($urandom_range(99) < pct);
    end
  endtask

  initial begin
    int idle_pct;
    int counted;
    int pick;
    logic [OP_W-1:0] op;
    int t;
    int lv;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, bad removes, unknown op, list edges
    issue(OP_POP, 63, 31);
    issue(OP_REMOVE, 0, 0);
    issue(OP_UNUSED, 63, 31);
    issue(OP_ENQUEUE, 0, 31);
    issue(OP_ENQUEUE, 63, 31);
    issue(OP_ENQUEUE, 5, 31);
    issue(OP_ENQUEUE, 1, 0);
    issue(OP_ENQUEUE, 62, 0);
    issue(OP_ENQUEUE, 0, 7);      // double enqueue
    issue(OP_REMOVE, 63, 0);      // middle of a list
    issue(OP_REMOVE, 5, 0);       // tail of a list
    issue(OP_REMOVE, 1, 0);       // head with a successor
    issue(OP_POP, 0, 0);
    issue(OP_POP, 0, 0);
    issue(OP_POP, 0, 0);          // empty again
    issue(OP_REMOVE, 62, 0);      // already popped
    issue(OP_ENQUEUE, 42, 21);
    issue(OP_ENQUEUE, 21, 10);
    issue(OP_REMOVE, 42, 0);      // only thread of its level
    issue(OP_POP, 0, 0);
    issue(OP_UNUSED, 0, 0);
    issue(OP_ENQUEUE, 63, 0);
    issue(OP_POP, 0, 31);

    // random phases with different sender idling
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 64 : (phase == 2) ? 7 : 0;
      counted = 0;
      while (counted < 225) begin
        sender_gap(idle_pct);
        pick = $urandom_range(99);
        if (pick < 45) op = OP_ENQUEUE;
        else if (pick < 70) op = OP_POP;
        else if (pick < 95) op = OP_REMOVE;
        else op = OP_UNUSED;
        // a small pool of threads and levels builds long lists
        t = $urandom_range(1) ? $urandom_range(7) : $urandom_range(THREADS - 1);
        lv = $urandom_range(3) ? $urandom_range(3) : $urandom_range(LEVELS - 1);
        issue(op, t, lv);
        if (op != OP_UNUSED) counted++;
      end
    end

    // drain the outstanding results
    start <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
